### hdl/hpti_pkg.sv
// ----------------------------------------------------------------------------
// hpti_pkg
// Shared types and constants for the hashed page table insert core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpti_pkg;

  localparam int GroupIndexBitsDefault = 11;
  localparam int HashBits              = 19;
  localparam int SlotsPerGroup         = 8;

  // Result status codes
  localparam logic [1:0] STAT_INSERTED = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_SKIPPED  = 2'd2;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRI,
    ST_SEC
  } back_state_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [31:0]         upper;   // PTE word 0, H bit clear
    logic [31:0]         lower;   // PTE word 1
    logic [HashBits-1:0] grp_p;   // primary group, already reduced
    logic [HashBits-1:0] grp_s;   // secondary group, already reduced
    logic                last;
  } item_t;

endpackage

### hdl/hpti_ram.sv
// ----------------------------------------------------------------------------
// hpti_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/hpti_front.sv
// ----------------------------------------------------------------------------
// hpti_front
// Accepts an item, builds both PTE words and both hash groups, and holds the
// result in a one-entry queue until the back end takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpti_front #(
  parameter int GROUP_INDEX_BITS = hpti_pkg::GroupIndexBitsDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [8:0]          cfg_data,
  input  logic                take,
  input  logic [15:0]         page_index,
  input  logic [23:0]         vsid,
  input  logic [19:0]         phys_page,
  input  logic [3:0]          wimg,
  input  logic [1:0]          page_protection,
  input  logic                last_in_range,
  input  logic                pop,
  output logic                item_valid,
  output hpti_pkg::item_t     item
);

  logic [8:0]                   table_mask;
  logic [hpti_pkg::HashBits-1:0] hash_p;
  logic [hpti_pkg::HashBits-1:0] hash_s;
  hpti_pkg::item_t              item_next;

  // HTABMASK register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_mask <= 9'd0;
    end else if (cfg_we) begin
      table_mask <= cfg_data;
    end
  end

  // Group index: low ten hash bits, masked upper bits, cut to table size
  function automatic logic [hpti_pkg::HashBits-1:0] group_of(
    input logic [hpti_pkg::HashBits-1:0] h,
    input logic [8:0]                    m
  );
    logic [hpti_pkg::HashBits-1:0] g;
    logic [hpti_pkg::HashBits-1:0] keep;
    g    = {h[18:10] & m, h[9:0]};
    keep = {{(hpti_pkg::HashBits - GROUP_INDEX_BITS){1'b0}},
            {GROUP_INDEX_BITS{1'b1}}};
    return g & keep;
  endfunction

  // Word and hash formation
  always_comb begin
    hash_p          = {3'b000, page_index} ^ vsid[18:0];
    hash_s          = ~hash_p;
    item_next.upper = {1'b1, vsid, 1'b0, page_index[15:10]};
    item_next.lower = {phys_page, 3'b000, 1'b1, 1'b1, wimg, 1'b0, page_protection};
    item_next.grp_p = group_of(hash_p, table_mask);
    item_next.grp_s = group_of(hash_s, table_mask);
    item_next.last  = last_in_range;
  end

  // One-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (pop) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= item_next;
    end
  end

endmodule

### hdl/hpti_back.sv
// ----------------------------------------------------------------------------
// hpti_back
// Clears the valid map after reset, then probes each unskipped item's primary
// group, then secondary if full; claims first free slot, reports the outcome.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpti_back #(
  parameter int GROUP_INDEX_BITS = hpti_pkg::GroupIndexBitsDefault
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  hpti_pkg::item_t item,
  output logic            pop,
  output logic            idle,
  output logic            done,
  output logic [1:0]      status,
  output logic            used_secondary,
  output logic [18:0]     group_index,
  output logic [2:0]      slot,
  output logic [31:0]     upper_word,
  output logic [31:0]     lower_word
);

  localparam int Groups = 1 << GROUP_INDEX_BITS;

  hpti_pkg::back_state_t       state, state_next;
  hpti_pkg::item_t             cur;
  logic [GROUP_INDEX_BITS-1:0] clr_cnt;
  logic                        range_failed, range_failed_next;

  logic                        ram_we;
  logic [GROUP_INDEX_BITS-1:0] ram_waddr, ram_raddr;
  logic [7:0]                  ram_wdata, row;

  logic                        found;
  logic [2:0]                  free_slot;
  logic [7:0]                  free_bit;

  logic                        done_next;
  logic [1:0]                  status_next;
  logic                        sec_next;
  logic [18:0]                 group_next;
  logic [2:0]                  slot_next;
  logic [31:0]                 upper_next, lower_next;

  // Valid bits, one row of eight per group
  hpti_ram #(.WIDTH(hpti_pkg::SlotsPerGroup), .DEPTH(Groups)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (row)
  );

  // First free slot in the row just read
  always_comb begin
    found     = 1'b0;
    free_slot = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!row[i]) begin
        found     = 1'b1;
        free_slot = 3'(i);
      end
    end
    free_bit = 8'b1 << free_slot;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      hpti_pkg::ST_CLEAR: if (&clr_cnt) state_next = hpti_pkg::ST_IDLE;
      hpti_pkg::ST_IDLE:  if (item_valid && !range_failed) state_next = hpti_pkg::ST_PRI;
      hpti_pkg::ST_PRI:   state_next = found ? hpti_pkg::ST_IDLE : hpti_pkg::ST_SEC;
      hpti_pkg::ST_SEC:   state_next = hpti_pkg::ST_IDLE;
      default:            state_next = hpti_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop               = 1'b0;
    idle              = (state == hpti_pkg::ST_IDLE);
    ram_we            = 1'b0;
    ram_waddr         = cur.grp_p[GROUP_INDEX_BITS-1:0];
    ram_wdata         = row | free_bit;
    ram_raddr         = cur.grp_s[GROUP_INDEX_BITS-1:0];
    range_failed_next = range_failed;
    done_next         = 1'b0;
    status_next       = hpti_pkg::STAT_INSERTED;
    sec_next          = 1'b0;
    group_next        = 19'd0;
    slot_next         = 3'd0;
    upper_next        = 32'd0;
    lower_next        = 32'd0;
    unique case (state)
      hpti_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = 8'd0;
      end
      hpti_pkg::ST_IDLE: begin
        ram_raddr = item.grp_p[GROUP_INDEX_BITS-1:0];
        pop       = item_valid;
        if (item_valid && range_failed) begin
          done_next   = 1'b1;
          status_next = hpti_pkg::STAT_SKIPPED;
          if (item.last) range_failed_next = 1'b0;
        end
      end
      hpti_pkg::ST_PRI: begin
        if (found) begin
          ram_we            = 1'b1;
          done_next         = 1'b1;
          group_next        = cur.grp_p;
          slot_next         = free_slot;
          upper_next        = cur.upper;
          lower_next        = cur.lower;
          range_failed_next = range_failed && !cur.last;
        end
      end
      hpti_pkg::ST_SEC: begin
        done_next = 1'b1;
        if (found) begin
          ram_we            = 1'b1;
          ram_waddr         = cur.grp_s[GROUP_INDEX_BITS-1:0];
          sec_next          = 1'b1;
          group_next        = cur.grp_s;
          slot_next         = free_slot;
          upper_next        = cur.upper | 32'h0000_0040;
          lower_next        = cur.lower;
          range_failed_next = range_failed && !cur.last;
        end else begin
          status_next       = hpti_pkg::STAT_FULL;
          range_failed_next = !cur.last;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= hpti_pkg::ST_CLEAR;
      clr_cnt      <= '0;
      range_failed <= 1'b0;
      done         <= 1'b0;
    end else begin
      state        <= state_next;
      clr_cnt      <= clr_cnt + 1'b1;
      range_failed <= range_failed_next;
      done         <= done_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) cur <= item;
    if (done_next) begin
      status         <= status_next;
      used_secondary <= sec_next;
      group_index    <= group_next;
      slot           <= slot_next;
      upper_word     <= upper_next;
      lower_word     <= lower_next;
    end
  end

  // Map writes never happen while waiting for work
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state != hpti_pkg::ST_IDLE) else $error("map write while idle");

  // No result while the map is still being cleared
  a_no_result_clear: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) != hpti_pkg::ST_CLEAR) else $error("result during clear");

  // A full or skipped result carries no placement
  a_empty_fail: assert property (@(posedge clk) disable iff (rst)
    done && status != hpti_pkg::STAT_INSERTED |-> upper_word == 32'd0 && slot == 3'd0)
    else $error("failed result carries data");

  // A secondary probe always ends with a result
  a_sec_done: assert property (@(posedge clk) disable iff (rst)
    state == hpti_pkg::ST_SEC |=> done) else $error("secondary probe lost");

endmodule

### hdl/hashed_page_table_insert_core.sv
// ----------------------------------------------------------------------------
// hashed_page_table_insert_core
// Inserts one page mapping per command into a hashed page table.
// ----------------------------------------------------------------------------
// Usage:
//   Drive the page fields and raise start; the command transfers at a clock
//   edge where start is high and busy is low. Each command gives exactly one
//   result on the result ports, marked by done for a single cycle; the
//   receiver cannot stall, so results must be taken when shown.
//   The user must write table_mask with cfg_we/cfg_data only while the core is idle; the core does not enforce this.
// Sequence:
//   Skipped page: result as the back end takes it from the queue. Insert into
//   the primary group: result after the primary probe. Secondary group or both
//   full: result after the primary and secondary probes. busy stays high until
//   the result is shown, so commands do not overlap; the limit is the one group
//   probe per cycle against the slot-valid map, whose read data is registered.
// Reset:
//   rst clears the skip flag and table_mask, then the core walks the valid
//   map, one group a cycle, clearing every group, with busy high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hashed_page_table_insert_core #(
  parameter int GROUP_INDEX_BITS = hpti_pkg::GroupIndexBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] page_index,
  input  logic [23:0] vsid,
  input  logic [19:0] phys_page,
  input  logic [3:0]  wimg,
  input  logic [1:0]  page_protection,
  input  logic        last_in_range,
  output logic        done,
  output logic [1:0]  status,
  output logic        used_secondary,
  output logic [18:0] group_index,
  output logic [2:0]  slot,
  output logic [31:0] upper_word,
  output logic [31:0] lower_word
);

  logic            take, pop, item_valid, back_idle;
  hpti_pkg::item_t item;

  // Busy while a command is queued, in flight, or the map is clearing
  assign busy = item_valid || !back_idle;
  assign take = start && !busy;

  hpti_front #(.GROUP_INDEX_BITS(GROUP_INDEX_BITS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .take            (take),
    .page_index      (page_index),
    .vsid            (vsid),
    .phys_page       (phys_page),
    .wimg            (wimg),
    .page_protection (page_protection),
    .last_in_range   (last_in_range),
    .pop             (pop),
    .item_valid      (item_valid),
    .item            (item)
  );

  hpti_back #(.GROUP_INDEX_BITS(GROUP_INDEX_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item           (item),
    .pop            (pop),
    .idle           (back_idle),
    .done           (done),
    .status         (status),
    .used_secondary (used_secondary),
    .group_index    (group_index),
    .slot           (slot),
    .upper_word     (upper_word),
    .lower_word     (lower_word)
  );

endmodule
